### sv/cls_pkg.sv
// ----------------------------------------------------------------------------
// cls_pkg
// Shared constants, command codes and structs for the cursor list store.
// ----------------------------------------------------------------------------
`default_nettype none

package cls_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 8;
    localparam int CMD_W    = 4;

    localparam logic [CMD_W-1:0] CMD_BEGIN      = 4'd0;
    localparam logic [CMD_W-1:0] CMD_END        = 4'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT       = 4'd2;
    localparam logic [CMD_W-1:0] CMD_PRIOR      = 4'd3;
    localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 4'd5;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 4'd6;
    localparam logic [CMD_W-1:0] CMD_REPLACE    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_READ       = 4'd8;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd9;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]  count;
        logic [IDX_W-1:0]  position;
        logic              is_empty;
        logic              is_full;
    } res_t;

endpackage

`default_nettype wire

### sv/cls_cmd_if.sv
// ----------------------------------------------------------------------------
// cls_cmd_if
// Command request channel: valid/ready with command and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface cls_cmd_if
    import cls_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

### sv/cls_rsp_if.sv
// ----------------------------------------------------------------------------
// cls_rsp_if
// Result request channel: valid/ready with the status fields of one command.
// ----------------------------------------------------------------------------
`default_nettype none

interface cls_rsp_if
    import cls_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              ok;
    logic [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]  count;
    logic [IDX_W-1:0]  position;
    logic              is_empty;
    logic              is_full;

    modport source (output valid, output ok, output read_value, output count,
                    output position, output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input read_value, input count,
                    input position, input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

### sv/cls_ram.sv
// ----------------------------------------------------------------------------
// cls_ram
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cls_ram
    import cls_pkg::*;
(
    input  wire logic              clk,
    input  wire ram_req_t          req,
    output logic [DATA_W-1:0]      rdata
);

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/cls_ctrl.sv
// ----------------------------------------------------------------------------
// cls_ctrl
// Command sequencer: holds count and cursor, walks shifts one entry at a
// time through a shared index step unit and the entry RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module cls_ctrl
    import cls_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    cls_cmd_if.sink           cmd,
    output ram_req_t          ram_req,
    input  wire logic [DATA_W-1:0] ram_rdata,
    output logic              res_valid,
    output res_t              res,
    input  wire logic         res_take
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_SHRD  = 6'b000100,
        S_SHWR  = 6'b001000,
        S_PUT   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic              up_reg, up_next;
    logic              rm_reg, rm_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  tgt_reg, tgt_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic              ok_reg, ok_next;
    logic [DATA_W-1:0] rd_reg, rd_next;

    logic              empty, full, more;
    logic [CNT_W-1:0]  step, used_dec;

    assign empty    = (used_reg == '0);
    assign full     = (used_reg == CNT_W'(CAPACITY));
    assign used_dec = used_reg - CNT_W'(1);

    // shared index step: down for an insert shift, up for a remove shift
    assign step = up_reg ? ({1'b0, idx_reg} - CNT_W'(1)) : ({1'b0, idx_reg} + CNT_W'(1));
    assign more = up_reg ? (idx_reg > tgt_reg) : (step < used_reg);

    assign cmd.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        up_next       = up_reg;
        rm_next       = rm_reg;
        idx_next      = idx_reg;
        tgt_next      = tgt_reg;
        val_next      = val_reg;
        used_next     = used_reg;
        cur_next      = cur_reg;
        ok_next       = ok_reg;
        rd_next       = rd_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = idx_reg;
        ram_req.wdata = ram_rdata;
        ram_req.raddr = cur_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    ok_next    = 1'b0;
                    rd_next    = '0;
                    val_next   = cmd.value;
                    rm_next    = 1'b0;
                    state_next = S_DONE;
                    unique case (cmd.command)
                        CMD_BEGIN:
                        begin
                            if (!empty)
                            begin
                                cur_next = '0;
                                ok_next  = 1'b1;
                            end
                        end
                        CMD_END:
                        begin
                            if (!empty)
                            begin
                                cur_next = used_dec[IDX_W-1:0];
                                ok_next  = 1'b1;
                            end
                        end
                        CMD_NEXT:
                        begin
                            if (!empty && (({1'b0, cur_reg} + CNT_W'(1)) < used_reg))
                            begin
                                cur_next = cur_reg + IDX_W'(1);
                                ok_next  = 1'b1;
                            end
                        end
                        CMD_PRIOR:
                        begin
                            if (!empty && (cur_reg != '0))
                            begin
                                cur_next = cur_reg - IDX_W'(1);
                                ok_next  = 1'b1;
                            end
                        end
                        CMD_INS_AFTER:
                        begin
                            if (!full)
                            begin
                                ok_next    = 1'b1;
                                up_next    = 1'b1;
                                idx_next   = used_reg[IDX_W-1:0];
                                tgt_next   = empty ? '0 : (cur_reg + IDX_W'(1));
                                state_next = S_SHRD;
                            end
                        end
                        CMD_INS_BEFORE:
                        begin
                            if (!empty && !full)
                            begin
                                ok_next    = 1'b1;
                                up_next    = 1'b1;
                                idx_next   = used_reg[IDX_W-1:0];
                                tgt_next   = cur_reg;
                                state_next = S_SHRD;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (!empty)
                            begin
                                ok_next    = 1'b1;
                                up_next    = 1'b0;
                                rm_next    = 1'b1;
                                idx_next   = cur_reg;
                                state_next = S_FETCH;
                            end
                        end
                        CMD_REPLACE:
                        begin
                            if (!empty)
                            begin
                                ok_next       = 1'b1;
                                ram_req.we    = 1'b1;
                                ram_req.waddr = cur_reg;
                                ram_req.wdata = cmd.value;
                            end
                        end
                        CMD_READ:
                        begin
                            if (!empty)
                            begin
                                ok_next    = 1'b1;
                                state_next = S_FETCH;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            ok_next   = !empty;
                            used_next = '0;
                            cur_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                rd_next    = ram_rdata;
                state_next = rm_reg ? S_SHRD : S_DONE;
            end
            S_SHRD:
            begin
                if (more)
                begin
                    ram_req.raddr = step[IDX_W-1:0];
                    state_next    = S_SHWR;
                end
                else if (up_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    used_next  = used_dec;
                    cur_next   = ({1'b0, cur_reg} >= used_dec) ? '0 : cur_reg;
                    state_next = S_DONE;
                end
            end
            S_SHWR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg;
                ram_req.wdata = ram_rdata;
                idx_next      = step[IDX_W-1:0];
                state_next    = S_SHRD;
            end
            S_PUT:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = tgt_reg;
                ram_req.wdata = val_reg;
                cur_next      = tgt_reg;
                used_next     = used_reg + CNT_W'(1);
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_valid      = (state_reg == S_DONE);
    assign res.ok         = ok_reg;
    assign res.read_value = rd_reg;
    assign res.count      = used_reg;
    assign res.position   = empty ? '0 : cur_reg;
    assign res.is_empty   = empty;
    assign res.is_full    = full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            cur_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            cur_reg   <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        up_reg  <= up_next;
        rm_reg  <= rm_next;
        idx_reg <= idx_next;
        tgt_reg <= tgt_next;
        val_reg <= val_next;
        ok_reg  <= ok_next;
        rd_reg  <= rd_next;
    end

endmodule

`default_nettype wire

### sv/cursor_list_store_core.sv
// ----------------------------------------------------------------------------
// cursor_list_store_core
// Ordered byte list with a cursor, held in a single-port-write RAM.
// ----------------------------------------------------------------------------
// One command is taken at a time. Cursor moves, replace, clear and any refused
// command go straight to the result state; a successful read passes through a
// fetch state first, and a successful insert or remove walks, one at a time,
// the entries that are moved to open or close the gap (up to 63). Each moved
// entry costs one RAM read and one RAM write on the single read and write
// ports. A result register on the output lets the next command be taken while
// the previous result still waits; a second result waits in the sequencer
// until that register drains.
`default_nettype none

module cursor_list_store_core
    import cls_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    cls_cmd_if.sink   cmd,
    cls_rsp_if.source rsp
);

    ram_req_t          ram_req;
    logic [DATA_W-1:0] ram_rdata;
    logic              res_valid;
    res_t              res;
    logic              res_take;
    logic              out_valid_reg, out_valid_next;
    res_t              out_data_reg;

    cls_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    cls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    assign res_take = res_valid && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.ok         = out_data_reg.ok;
    assign rsp.read_value = out_data_reg.read_value;
    assign rsp.count      = out_data_reg.count;
    assign rsp.position   = out_data_reg.position;
    assign rsp.is_empty   = out_data_reg.is_empty;
    assign rsp.is_full    = out_data_reg.is_full;

endmodule

`default_nettype wire

### sv/cls_checker.sv
// ----------------------------------------------------------------------------
// cls_checker
// Port-level checks on the cursor list store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cls_checker
    import cls_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              cmd_valid,
    input wire logic              cmd_ready,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic              rsp_ok,
    input wire logic [CNT_W-1:0]  rsp_count,
    input wire logic [IDX_W-1:0]  rsp_position,
    input wire logic              rsp_is_empty,
    input wire logic              rsp_is_full
);

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_is_empty == (rsp_count == '0)))
        else $error("is_empty disagrees with count");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_is_full == (rsp_count == CNT_W'(CAPACITY))))
        else $error("is_full disagrees with count");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp_count == '0 && rsp_position == '0)
                    || ({1'b0, rsp_position} < rsp_count)))
        else $error("cursor out of range");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("command taken while busy");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_ok)
                                       && $stable(rsp_count)))
        else $error("stalled result changed");

endmodule

bind cursor_list_store_core cls_checker u_cls_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_ok       (rsp.ok),
    .rsp_count    (rsp.count),
    .rsp_position (rsp.position),
    .rsp_is_empty (rsp.is_empty),
    .rsp_is_full  (rsp.is_full)
);

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks cursor_list_store_core against a cycle-free list predictor. Directed
// requests walk the refusal cases and every command, a fill-to-capacity pass
// covers the full list, then random grow/shrink traffic runs under several
// sender-gap and receiver-stall mixes. Each result is compared field by field.
// ----------------------------------------------------------------------------

module tb;
    import cls_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd10;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;
    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE_LEN   = 160;
    localparam int MAX_GAP      = 30;
    localparam int MAX_REPORTS  = 200;
    localparam int PHASE_ITEMS  = 200;
    localparam int TREND_LEN    = 100;

    logic clk;
    logic rst_n;

    cls_cmd_if cmd_ch ();
    cls_rsp_if rsp_ch ();

    cursor_list_store_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    logic [DATA_W-1:0] list_entries [CAPACITY];
    int                list_len;
    int                cursor_at;
    res_t              expected_results [$];
    int                error_count;
    int                result_index;
    int                quiet_cycles;
    int                gap_pct;
    int                stall_pct;

    always #6 clk = ~clk;

    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_REPORTS)
            $display("result %0d: %s got 0x%0h want 0x%0h", result_index, what, got, want);
        error_count++;
    endtask

    function automatic res_t predict_list_step(input logic [CMD_W-1:0] op,
                                               input logic [DATA_W-1:0] val);
        res_t r;
        int   i;
        r = '0;
        case (op)
            CMD_BEGIN:
                if (list_len != 0)
                begin
                    cursor_at = 0;
                    r.ok = 1'b1;
                end
            CMD_END:
                if (list_len != 0)
                begin
                    cursor_at = list_len - 1;
                    r.ok = 1'b1;
                end
            CMD_NEXT:
                if (list_len != 0 && cursor_at + 1 < list_len)
                begin
                    cursor_at++;
                    r.ok = 1'b1;
                end
            CMD_PRIOR:
                if (list_len != 0 && cursor_at > 0)
                begin
                    cursor_at--;
                    r.ok = 1'b1;
                end
            CMD_INS_AFTER:
                if (list_len < CAPACITY)
                begin
                    if (list_len == 0)
                    begin
                        list_entries[0] = val;
                        cursor_at = 0;
                    end
                    else
                    begin
                        for (i = list_len; i > cursor_at + 1; i--)
                            list_entries[i] = list_entries[i-1];
                        cursor_at++;
                        list_entries[cursor_at] = val;
                    end
                    list_len++;
                    r.ok = 1'b1;
                end
            CMD_INS_BEFORE:
                if (list_len != 0 && list_len < CAPACITY)
                begin
                    for (i = list_len; i > cursor_at; i--)
                        list_entries[i] = list_entries[i-1];
                    list_entries[cursor_at] = val;
                    list_len++;
                    r.ok = 1'b1;
                end
            CMD_REMOVE:
                if (list_len != 0)
                begin
                    r.read_value = list_entries[cursor_at];
                    for (i = cursor_at; i + 1 < list_len; i++)
                        list_entries[i] = list_entries[i+1];
                    list_len--;
                    if (cursor_at >= list_len)
                        cursor_at = 0;
                    r.ok = 1'b1;
                end
            CMD_REPLACE:
                if (list_len != 0)
                begin
                    list_entries[cursor_at] = val;
                    r.ok = 1'b1;
                end
            CMD_READ:
                if (list_len != 0)
                begin
                    r.read_value = list_entries[cursor_at];
                    r.ok = 1'b1;
                end
            CMD_CLEAR:
            begin
                r.ok = (list_len != 0);
                list_len = 0;
                cursor_at = 0;
            end
            default:
                ;
        endcase
        r.count    = CNT_W'(list_len);
        r.position = (list_len == 0) ? '0 : IDX_W'(cursor_at);
        r.is_empty = (list_len == 0);
        r.is_full  = (list_len >= CAPACITY);
        return r;
    endfunction

    task automatic compare_result(input res_t got, input res_t want);
        if (got.ok !== want.ok)
            report_mismatch("ok", int'(got.ok), int'(want.ok));
        if (got.read_value !== want.read_value)
            report_mismatch("read_value", int'(got.read_value), int'(want.read_value));
        if (got.count !== want.count)
            report_mismatch("count", int'(got.count), int'(want.count));
        if (got.position !== want.position)
            report_mismatch("position", int'(got.position), int'(want.position));
        if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", int'(got.is_empty), int'(want.is_empty));
        if (got.is_full !== want.is_full)
            report_mismatch("is_full", int'(got.is_full), int'(want.is_full));
    endtask

    // results are checked before the same edge's request is predicted
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.ok         = rsp_ch.ok;
                got.read_value = rsp_ch.read_value;
                got.count      = rsp_ch.count;
                got.position   = rsp_ch.position;
                got.is_empty   = rsp_ch.is_empty;
                got.is_full    = rsp_ch.is_full;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                    compare_result(got, expected_results.pop_front());
                result_index++;
            end
            if (cmd_ch.valid && cmd_ch.ready)
                expected_results.push_back(predict_list_step(cmd_ch.command, cmd_ch.value));
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no request moved in %0d cycles", QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] val);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            cmd_ch.valid   <= 1'b0;
            cmd_ch.command <= CMD_W'($urandom);
            cmd_ch.value   <= DATA_W'($urandom);
            gap++;
        end
        @(negedge clk);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= op;
        cmd_ch.value   <= val;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [CMD_W-1:0] pick_command(input bit grow);
        int r;
        int ins;
        int rem;
        r   = $urandom_range(99);
        ins = grow ? 55 : 15;
        rem = grow ? 8 : 40;
        if (r < ins)
            return (r % 2 == 0) ? CMD_INS_AFTER : CMD_INS_BEFORE;
        r -= ins;
        if (r < rem)
            return CMD_REMOVE;
        r -= rem;
        if (r == 0)
            return grow ? CMD_READ : CMD_CLEAR;
        if (r == 1)
            return CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        case (r % 6)
            0: return CMD_NEXT;
            1: return CMD_PRIOR;
            2: return CMD_BEGIN;
            3: return CMD_END;
            4: return CMD_REPLACE;
            default: return CMD_READ;
        endcase
    endfunction

    task automatic test_empty_list();
        send_request(CMD_BEGIN, 8'h00);
        send_request(CMD_END, 8'hFF);
        send_request(CMD_NEXT, 8'h00);
        send_request(CMD_PRIOR, 8'h00);
        send_request(CMD_INS_BEFORE, 8'hFF);
        send_request(CMD_REMOVE, 8'h00);
        send_request(CMD_REPLACE, 8'hFF);
        send_request(CMD_READ, 8'h00);
        send_request(CMD_CLEAR, 8'h00);
        send_request(CMD_UNUSED_LO, 8'hFF);
        send_request(CMD_UNUSED_HI, 8'h00);
    endtask

    task automatic test_edit_ops();
        send_request(CMD_INS_AFTER, 8'h00);
        send_request(CMD_INS_AFTER, 8'hFF);
        send_request(CMD_INS_BEFORE, 8'hA5);
        send_request(CMD_BEGIN, 8'h00);
        send_request(CMD_PRIOR, 8'h00);
        send_request(CMD_READ, 8'h00);
        send_request(CMD_END, 8'h00);
        send_request(CMD_NEXT, 8'h00);
        send_request(CMD_REPLACE, 8'h5A);
        send_request(CMD_REMOVE, 8'h00);
        send_request(CMD_NEXT, 8'h00);
        send_request(CMD_REMOVE, 8'h00);
        send_request(CMD_REMOVE, 8'h00);
        send_request(CMD_INS_AFTER, 8'h3C);
        send_request(CMD_CLEAR, 8'h00);
    endtask

    // fill to full, hit refused inserts, then drain by removes mixed with random moves
    task automatic test_capacity();
        int k;
        for (k = 0; k < CAPACITY; k++)
            send_request(($urandom_range(1) == 0 || k == 0) ? CMD_INS_AFTER : CMD_INS_BEFORE,
                         DATA_W'($urandom));
        send_request(CMD_INS_AFTER, DATA_W'($urandom));
        send_request(CMD_INS_BEFORE, DATA_W'($urandom));
        send_request(CMD_END, 8'h00);
        send_request(CMD_NEXT, 8'h00);
        wait_all_results();
        send_request(CMD_READ, 8'h00);
        send_request(CMD_REPLACE, DATA_W'($urandom));
        send_request(CMD_READ, 8'h00);
        send_request(CMD_BEGIN, 8'h00);
        while (list_len != 0)
        begin
            if ($urandom_range(3) == 0)
                send_request($urandom_range(1) ? CMD_NEXT : CMD_PRIOR, 8'h00);
            send_request(CMD_REMOVE, 8'h00);
        end
    endtask

    task automatic test_random_traffic(input int items, input int gap, input int stall);
        int k;
        gap_pct   = gap;
        stall_pct = stall;
        for (k = 0; k < items; k++)
            send_request(pick_command((k / TREND_LEN) % 2 == 0), DATA_W'($urandom));
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.command = CMD_BEGIN;
        cmd_ch.value   = '0;
        rsp_ch.ready   = 1'b0;
        list_len       = 0;
        cursor_at      = 0;
        error_count    = 0;
        result_index   = 0;
        quiet_cycles   = 0;
        gap_pct        = 0;
        stall_pct      = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_edit_ops();
        gap_pct   = 15;
        stall_pct = 15;
        test_capacity();
        test_random_traffic(PHASE_ITEMS, 0, 0);
        test_random_traffic(PHASE_ITEMS, 61, 0);
        test_random_traffic(PHASE_ITEMS, 0, 61);
        test_random_traffic(PHASE_ITEMS, 15, 15);
        test_random_traffic(PHASE_ITEMS, 0, 0);

        wait_all_results();
        repeat (SETTLE_LEN) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
sv/cls_pkg.sv
sv/cls_cmd_if.sv
sv/cls_rsp_if.sv
sv/cls_ram.sv
sv/cls_ctrl.sv
sv/cursor_list_store_core.sv
sv/cls_checker.sv
test/tb.sv
